// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off while in reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rpa_pkg.sv =====
// Types, constants and helper functions for the pixel to glyph/color pipeline.
package rpa_pkg;

  localparam int IN_W  = 24;
  localparam int OUT_W = 16;

  localparam int SQ_X_W  = 25;
  localparam int SQ_ITER = 13;
  localparam int SQ_STG  = 7;

  localparam logic [8:0]  W_RED     = 9'd306;
  localparam logic [9:0]  W_GREEN   = 10'd601;
  localparam logic [6:0]  W_BLUE    = 7'd117;
  localparam logic [3:0]  RAMP_MUL  = 4'd11;
  localparam logic [5:0]  RAMP_MAX  = 6'd32;
  localparam int          CUBE_STEP = 48;
  localparam int          CUBE_MAX  = 5;
  localparam logic [7:0]  CUBE_BASE = 8'd16;
  localparam logic [7:0]  CUBE_R    = 8'd36;
  localparam logic [7:0]  CUBE_G    = 8'd6;

  localparam logic [6:0] CH_SPACE   = 7'd32;
  localparam logic [6:0] CH_DOT     = 7'd46;
  localparam logic [6:0] CH_COLON   = 7'd58;
  localparam logic [6:0] CH_DASH    = 7'd45;
  localparam logic [6:0] CH_EQUAL   = 7'd61;
  localparam logic [6:0] CH_PLUS    = 7'd43;
  localparam logic [6:0] CH_STAR    = 7'd42;
  localparam logic [6:0] CH_HASH    = 7'd35;
  localparam logic [6:0] CH_PERCENT = 7'd37;
  localparam logic [6:0] CH_AT      = 7'd64;

  typedef struct packed {
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic              last;
    logic [5:0]        idx;
    logic [SQ_X_W-1:0] x;
    logic [SQ_X_W-1:0] res;
  } sq_t;

  function automatic logic [6:0] ramp_char(input logic [5:0] idx);
    logic [6:0] ch;
    if (idx == 6'd0)       ch = CH_SPACE;
    else if (idx <= 6'd2)  ch = CH_DOT;
    else if (idx <= 6'd4)  ch = CH_COLON;
    else if (idx <= 6'd6)  ch = CH_DASH;
    else if (idx <= 6'd8)  ch = CH_EQUAL;
    else if (idx <= 6'd11) ch = CH_PLUS;
    else if (idx <= 6'd14) ch = CH_STAR;
    else if (idx <= 6'd17) ch = CH_HASH;
    else if (idx <= 6'd25) ch = CH_PERCENT;
    else                   ch = CH_AT;
    return ch;
  endfunction

  // |2c - p| in Q4, truncated to integer, divided by the cube step, saturated.
  function automatic logic [2:0] cube_level(input logic [7:0] c, input logic [12:0] pq);
    logic [12:0] twice;
    logic [12:0] mag;
    logic [8:0]  m;
    logic [2:0]  q;
    twice = {c, 5'b0};
    mag   = (twice >= pq) ? (twice - pq) : (pq - twice);
    m     = mag[12:4];
    q     = 3'd0;
    for (int k = 1; k <= CUBE_MAX; k++) begin
      if (m >= 9'(CUBE_STEP * k)) q = 3'(k);
    end
    return q;
  endfunction

endpackage

// ===== rtl/rgb_pixel_to_ascii_glyph_and_color.sv =====
// Streaming pixel to ASCII ramp glyph and 256-color palette index pipeline.
//
//  channel  | dir | contents
//  ---------+-----+-----------------------------------------------
//  s_axis   | in  | tdata {red, green, blue}, tlast = line_end
//  m_axis   | out | tdata {pad, color_index, glyph}, tlast = row_end
//  cfg      | in  | cfg_we / cfg_wdata = full_palette
//
// Eleven register stages: squares, weighted sum and ramp index, seven
// square-root stages (two bits of the root each, one in the last), cube
// levels, output. One pixel per clock while m_axis does not stall. Reset
// empties every stage and sets full_palette. A stall on m_axis holds all
// full stages up to the first bubble; a stage with a bubble keeps accepting.
module rgb_pixel_to_ascii_glyph_and_color (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [rpa_pkg::IN_W-1:0]   s_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rpa_pkg::OUT_W-1:0]  m_tdata,   // glyph[6:0], color_index[14:7], zero[15]
  output logic                       m_tlast,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata
);
  import rpa_pkg::*;

  logic full_palette;

  // stage 1: squares
  logic        v1;
  logic [7:0]  b1, g1, r1;
  logic        l1;
  logic [15:0] bb1, gg1, rr1;
  logic [9:0]  sum1;

  // stage 2 and root stages
  logic [SQ_STG:0] vs;
  logic [SQ_STG:0] rs;
  sq_t             sq      [SQ_STG+1];
  sq_t             sq_next [SQ_STG+1];

  // cube level stage
  logic       vq;
  logic [2:0] qr, qg, qb;
  logic [5:0] idxq;
  logic       lq;

  // output stage
  logic       vo;
  logic [6:0] glyph;
  logic [7:0] color_index;
  logic       row_end;

  logic rdy_o, rdy_q, rdy_1;

  assign rdy_o = !vo || m_tready;
  assign rdy_q = !vq || rdy_o;
  assign rs[SQ_STG] = !vs[SQ_STG] || rdy_q;
  for (genvar k = 0; k < SQ_STG; k++) begin : g_rdy
    assign rs[k] = !vs[k] || rs[k+1];
  end
  assign rdy_1    = !v1 || rs[0];
  assign s_tready = rdy_1;

  always_ff @(posedge clk) begin
    if (rst) full_palette <= 1'b1;
    else if (cfg_we) full_palette <= cfg_wdata;
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (rdy_1) v1 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (rdy_1) begin
      b1   <= s_tdata[7:0];
      g1   <= s_tdata[15:8];
      r1   <= s_tdata[23:16];
      l1   <= s_tlast;
      bb1  <= 16'(s_tdata[7:0]) * 16'(s_tdata[7:0]);
      gg1  <= 16'(s_tdata[15:8]) * 16'(s_tdata[15:8]);
      rr1  <= 16'(s_tdata[23:16]) * 16'(s_tdata[23:16]);
      sum1 <= 10'(s_tdata[7:0]) + 10'(s_tdata[15:8]) + 10'(s_tdata[23:16]);
    end
  end

  // stage 2: weighted sum of squares, ramp index = floor(11*sum/255), saturated at 32
  always_comb begin
    logic [26:0] s_w;
    logic [13:0] t11;
    logic [13:0] tq;
    logic [5:0]  ix;
    s_w = 27'(rr1) * 27'(W_RED) + 27'(gg1) * 27'(W_GREEN) + 27'(bb1) * 27'(W_BLUE);
    t11 = 14'(sum1) * 14'(RAMP_MUL);
    tq  = (t11 + 14'd1 + 14'(t11[13:8])) >> 8;
    ix  = tq[5:0];
    if (ix > RAMP_MAX) ix = RAMP_MAX;
    sq_next[0].blue  = b1;
    sq_next[0].green = g1;
    sq_next[0].red   = r1;
    sq_next[0].last  = l1;
    sq_next[0].idx   = ix;
    sq_next[0].x     = s_w[26:2];
    sq_next[0].res   = '0;
  end

  // root stages: two iterations of the digit-by-digit square root each, one in the last
  for (genvar k = 1; k <= SQ_STG; k++) begin : g_sq
    always_comb begin
      logic [SQ_X_W:0] xt;
      logic [SQ_X_W:0] rt;
      logic [SQ_X_W:0] bt;
      int              it;
      sq_next[k] = sq[k-1];
      xt = {1'b0, sq[k-1].x};
      rt = {1'b0, sq[k-1].res};
      for (int j = 0; j < 2; j++) begin
        it = 2 * (k - 1) + j;
        if (it < SQ_ITER) begin
          bt = (SQ_X_W+1)'(1) << (2 * (SQ_ITER - 1 - it));
          if (xt >= rt + bt) begin
            xt = xt - (rt + bt);
            rt = (rt >> 1) + bt;
          end else begin
            rt = rt >> 1;
          end
        end
      end
      sq_next[k].x   = xt[SQ_X_W-1:0];
      sq_next[k].res = rt[SQ_X_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vs[0] <= 1'b0;
    else if (rs[0]) vs[0] <= v1;
  end

  always_ff @(posedge clk) begin
    if (rs[0]) sq[0] <= sq_next[0];
  end

  for (genvar k = 1; k <= SQ_STG; k++) begin : g_sq_reg
    always_ff @(posedge clk) begin
      if (rst) vs[k] <= 1'b0;
      else if (rs[k]) vs[k] <= vs[k-1];
    end

    always_ff @(posedge clk) begin
      if (rs[k]) sq[k] <= sq_next[k];
    end
  end

  // cube levels
  always_ff @(posedge clk) begin
    if (rst) vq <= 1'b0;
    else if (rdy_q) vq <= vs[SQ_STG];
  end

  always_ff @(posedge clk) begin
    if (rdy_q) begin
      qr   <= cube_level(sq[SQ_STG].red,   sq[SQ_STG].res[12:0]);
      qg   <= cube_level(sq[SQ_STG].green, sq[SQ_STG].res[12:0]);
      qb   <= cube_level(sq[SQ_STG].blue,  sq[SQ_STG].res[12:0]);
      idxq <= sq[SQ_STG].idx;
      lq   <= sq[SQ_STG].last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) vo <= 1'b0;
    else if (rdy_o) vo <= vq;
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      glyph       <= ramp_char(idxq);
      color_index <= full_palette ?
                     (CUBE_BASE + 8'(qr) * CUBE_R + 8'(qg) * CUBE_G + 8'(qb)) : 8'd0;
      row_end     <= lq;
    end
  end

  assign m_tvalid = vo;
  assign m_tdata  = {1'b0, color_index, glyph};
  assign m_tlast  = row_end;

endmodule

// ===== rtl/rpa_checker.sv =====
// Port-level checker for the pixel to glyph/color pipeline, bound to the top level.
`include "assert_macros.svh"

module rpa_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [rpa_pkg::OUT_W-1:0]  m_tdata,
  input logic                       m_tlast
);
  import rpa_pkg::*;

  `ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
  `ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
  `ASSERT_IMPL(a_empty_after_reset, $past(rst), !m_tvalid)
  `ASSERT_IMPL(a_glyph_range, m_tvalid, m_tdata[6:0] >= CH_SPACE && m_tdata[6:0] <= CH_AT)
  `ASSERT_IMPL(a_color_range, m_tvalid, m_tdata[14:7] <= 8'd231 && !m_tdata[15])

endmodule

bind rgb_pixel_to_ascii_glyph_and_color rpa_checker u_rpa_checker (.*);
